/* rtl/kwlex_pkg.sv */
// ----------------------------------------------------------------------------
// kwlex_pkg
// Shared types, token codes and keyword tables of the keyword token lexer.
// ----------------------------------------------------------------------------
package kwlex_pkg;

    // Kept-length limits and offset counter width
    localparam int IDENT_KEEP  = 127;
    localparam int NUMBER_KEEP = 63;
    localparam int OFFSET_BITS = 32;

    // Field widths
    localparam int KIND_W   = 5;
    localparam int START_W  = 32;
    localparam int LENGTH_W = 7;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Lexer modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_COMMENT = 2'd1;
    localparam logic [1:0] MODE_IDENT   = 2'd2;
    localparam logic [1:0] MODE_NUMBER  = 2'd3;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_EOF     = 5'd0;
    localparam logic [KIND_W-1:0] KIND_LBRACE  = 5'd1;
    localparam logic [KIND_W-1:0] KIND_RBRACE  = 5'd2;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 5'd3;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 5'd4;
    localparam logic [KIND_W-1:0] KIND_COMMA   = 5'd5;
    localparam logic [KIND_W-1:0] KIND_EQUALS  = 5'd6;
    localparam logic [KIND_W-1:0] KIND_COLON   = 5'd7;
    localparam logic [KIND_W-1:0] KIND_KW_BASE = 5'd8;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd16;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd17;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd18;

    // Request types
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_EOF  = 1'b1;

    // Character codes
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // Keyword table: text left-aligned, first character in the top byte
    localparam int KW_COUNT = 8;
    localparam int KW_CHARS = 9;
    localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_COUNT] = '{
        {"network",   16'h0},
        {"input",     32'h0},
        {"conv2d",    24'h0},
        {"maxpool2d"},
        {"flatten",   16'h0},
        {"dense",     32'h0},
        {"output",    24'h0},
        {"train",     32'h0}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd7, 4'd5, 4'd6, 4'd9, 4'd7, 4'd5, 4'd6, 4'd5
    };

    // One result beat
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
        logic                truncated;
        logic                last;
    } token_t;

    // Results caused by one input beat
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } step_out_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // Character of keyword k at position p, zero past the table width
    function automatic logic [7:0] kw_char(input int k, input logic [LENGTH_W-1:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        if (int'(p) < KW_CHARS)
        begin
            ch = KW_TEXT[k][(KW_CHARS - 1 - int'(p)) * 8 +: 8];
        end
        return ch;
    endfunction

    // Drop keyword candidates that do not match c at position pos
    function automatic logic [KW_COUNT-1:0] narrow_candidates(
        input logic [KW_COUNT-1:0] cand,
        input logic [LENGTH_W-1:0] pos,
        input logic [7:0]          c
    );
        logic [KW_COUNT-1:0] res;
        res = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            res[k] = cand[k] && (pos < LENGTH_W'(KW_LEN[k])) && (kw_char(k, pos) == c);
        end
        return res;
    endfunction

endpackage

/* rtl/kwlex_core.sv */
// ----------------------------------------------------------------------------
// kwlex_core
// Lexer state and the per-beat step: turns one registered input beat into
// zero, one or two tokens and updates the scanning state.
// ----------------------------------------------------------------------------
module kwlex_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                req_type,
    input  logic [7:0]          in_char,
    output kwlex_pkg::step_out_t step
);

    logic [1:0]                              mode_reg, mode_next;
    logic [kwlex_pkg::LENGTH_W-1:0]          kept_reg, kept_next;
    logic [kwlex_pkg::OFFSET_BITS-1:0]       origin_reg, origin_next;
    logic [kwlex_pkg::OFFSET_BITS-1:0]       pos_reg, pos_next;
    logic [kwlex_pkg::KW_COUNT-1:0]          cand_reg, cand_next;
    logic                                    ovf_reg, ovf_next;

    kwlex_pkg::token_t                       tok_flush, tok_new;
    logic                                    has_flush, has_new;
    logic                                    relex;
    logic                                    word_char;
    logic [kwlex_pkg::KIND_W-1:0]            pend_kind;
    logic [kwlex_pkg::KIND_W-1:0]            single_kind;

    // Classify the pending token: keyword when a candidate matches the kept length
    always_comb
    begin
        pend_kind = (mode_reg == kwlex_pkg::MODE_NUMBER) ? kwlex_pkg::KIND_NUMBER
                                                         : kwlex_pkg::KIND_IDENT;
        if (mode_reg == kwlex_pkg::MODE_IDENT)
        begin
            for (int k = 0; k < kwlex_pkg::KW_COUNT; k++)
            begin
                if (cand_reg[k] && (kwlex_pkg::LENGTH_W'(kwlex_pkg::KW_LEN[k]) == kept_reg))
                begin
                    pend_kind = kwlex_pkg::KIND_KW_BASE + kwlex_pkg::KIND_W'(k);
                end
            end
        end
    end

    // Map a punctuation byte to its token kind
    always_comb
    begin
        unique case (in_char)
            kwlex_pkg::CH_LBRACE: single_kind = kwlex_pkg::KIND_LBRACE;
            kwlex_pkg::CH_RBRACE: single_kind = kwlex_pkg::KIND_RBRACE;
            kwlex_pkg::CH_LPAREN: single_kind = kwlex_pkg::KIND_LPAREN;
            kwlex_pkg::CH_RPAREN: single_kind = kwlex_pkg::KIND_RPAREN;
            kwlex_pkg::CH_COMMA:  single_kind = kwlex_pkg::KIND_COMMA;
            kwlex_pkg::CH_EQUALS: single_kind = kwlex_pkg::KIND_EQUALS;
            kwlex_pkg::CH_COLON:  single_kind = kwlex_pkg::KIND_COLON;
            default:              single_kind = kwlex_pkg::KIND_UNKNOWN;
        endcase
    end

    assign word_char = kwlex_pkg::is_alpha(in_char) || kwlex_pkg::is_digit(in_char)
                       || (in_char == kwlex_pkg::CH_UNDER);

    // Step the scanner by one beat
    always_comb
    begin
        mode_next   = mode_reg;
        kept_next   = kept_reg;
        origin_next = origin_reg;
        pos_next    = pos_reg;
        cand_next   = cand_reg;
        ovf_next    = ovf_reg;
        has_flush   = 1'b0;
        has_new     = 1'b0;
        relex       = 1'b0;

        tok_flush.kind      = pend_kind;
        tok_flush.start     = kwlex_pkg::START_W'(origin_reg);
        tok_flush.length    = kept_reg;
        tok_flush.truncated = ovf_reg;
        tok_flush.last      = 1'b0;

        tok_new.kind        = single_kind;
        tok_new.start       = kwlex_pkg::START_W'(pos_reg);
        tok_new.length      = kwlex_pkg::LENGTH_W'(1);
        tok_new.truncated   = 1'b0;
        tok_new.last        = 1'b0;

        if (req_type == kwlex_pkg::REQ_EOF)
        begin
            // Flush the pending token, emit eof, return to reset state
            has_flush   = (mode_reg == kwlex_pkg::MODE_IDENT)
                          || (mode_reg == kwlex_pkg::MODE_NUMBER);
            has_new     = 1'b1;
            tok_new.kind   = kwlex_pkg::KIND_EOF;
            tok_new.length = '0;
            mode_next   = kwlex_pkg::MODE_IDLE;
            kept_next   = '0;
            origin_next = '0;
            pos_next    = '0;
            cand_next   = '1;
            ovf_next    = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + kwlex_pkg::OFFSET_BITS'(1);
            unique case (mode_reg)
                kwlex_pkg::MODE_COMMENT:
                begin
                    if (in_char == kwlex_pkg::CH_LF)
                    begin
                        mode_next = kwlex_pkg::MODE_IDLE;
                    end
                end
                kwlex_pkg::MODE_IDENT:
                begin
                    if (word_char)
                    begin
                        if (kept_reg < kwlex_pkg::LENGTH_W'(kwlex_pkg::IDENT_KEEP))
                        begin
                            cand_next = kwlex_pkg::narrow_candidates(cand_reg, kept_reg, in_char);
                            kept_next = kept_reg + kwlex_pkg::LENGTH_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        has_flush = 1'b1;
                        mode_next = kwlex_pkg::MODE_IDLE;
                        relex     = 1'b1;
                    end
                end
                kwlex_pkg::MODE_NUMBER:
                begin
                    if (kwlex_pkg::is_digit(in_char))
                    begin
                        if (kept_reg < kwlex_pkg::LENGTH_W'(kwlex_pkg::NUMBER_KEEP))
                        begin
                            kept_next = kept_reg + kwlex_pkg::LENGTH_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        has_flush = 1'b1;
                        mode_next = kwlex_pkg::MODE_IDLE;
                        relex     = 1'b1;
                    end
                end
                default:
                begin
                    relex = 1'b1;
                end
            endcase

            // Lex the byte afresh from idle
            if (relex)
            begin
                priority if (kwlex_pkg::is_space(in_char))
                begin
                    mode_next = kwlex_pkg::MODE_IDLE;
                end
                else if (in_char == kwlex_pkg::CH_HASH)
                begin
                    mode_next = kwlex_pkg::MODE_COMMENT;
                end
                else if (kwlex_pkg::is_alpha(in_char))
                begin
                    mode_next   = kwlex_pkg::MODE_IDENT;
                    origin_next = pos_reg;
                    kept_next   = kwlex_pkg::LENGTH_W'(1);
                    ovf_next    = 1'b0;
                    cand_next   = kwlex_pkg::narrow_candidates('1, '0, in_char);
                end
                else if (kwlex_pkg::is_digit(in_char))
                begin
                    mode_next   = kwlex_pkg::MODE_NUMBER;
                    origin_next = pos_reg;
                    kept_next   = kwlex_pkg::LENGTH_W'(1);
                    ovf_next    = 1'b0;
                    cand_next   = '1;
                end
                else
                begin
                    mode_next = kwlex_pkg::MODE_IDLE;
                    has_new   = 1'b1;
                end
            end
        end
    end

    // Pack the results in order and mark the final one
    always_comb
    begin
        step.count  = {1'b0, has_flush} + {1'b0, has_new};
        step.first  = has_flush ? tok_flush : tok_new;
        step.second = tok_new;
        if (has_flush && has_new)
        begin
            step.second.last = 1'b1;
        end
        else
        begin
            step.first.last = 1'b1;
        end
    end

    // Hold state until a beat is stepped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= kwlex_pkg::MODE_IDLE;
            kept_reg   <= '0;
            origin_reg <= '0;
            pos_reg    <= '0;
            cand_reg   <= '1;
            ovf_reg    <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            kept_reg   <= kept_next;
            origin_reg <= origin_next;
            pos_reg    <= pos_next;
            cand_reg   <= cand_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

/* rtl/keyword_token_lexer_top.sv */
// ----------------------------------------------------------------------------
// keyword_token_lexer_top
// Streaming lexer with incremental keyword match, one byte per beat.
// ----------------------------------------------------------------------------
// The lexer takes one byte beat per clock cycle while the result queue can
// take two tokens: a beat is captured in an input register, stepped through
// the scanner once the queue can take two tokens, and its tokens land in a
// four-entry result queue that drives the output port. Two tokens
// come from one beat only when punctuation, an unknown byte or end of input
// ends a pending identifier or number, and such a beat always follows a word
// byte that gives no token. With the output always ready, at most two tokens
// wait and the input sustains one beat per cycle. Under output back-pressure
// the input stalls whenever more than two tokens are waiting.
// ----------------------------------------------------------------------------
module keyword_token_lexer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] token_start, [38:32] token_length,
                                        // [39] truncated
    output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
    output logic        m_axis_tlast    // last_of_run
);

    logic                               in_valid_reg, in_valid_next;
    logic                               in_type_reg;
    logic [7:0]                         in_char_reg;
    logic                               s_accept;
    logic                               fire;
    kwlex_pkg::step_out_t               step;

    kwlex_pkg::token_t                  queue_reg [kwlex_pkg::Q_DEPTH];
    logic [kwlex_pkg::Q_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [kwlex_pkg::Q_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [kwlex_pkg::Q_CNT_W-1:0]      count_reg, count_next;
    logic [kwlex_pkg::Q_PTR_W-1:0]      wr_ptr_plus1;
    logic                               pop;
    kwlex_pkg::token_t                  head;

    // Step a beat only when the queue can take two tokens
    assign fire          = in_valid_reg
                           && (count_reg <= kwlex_pkg::Q_CNT_W'(kwlex_pkg::Q_DEPTH - 2));
    assign s_axis_tready = !in_valid_reg || fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_type_reg <= s_axis_tuser;
            in_char_reg <= s_axis_tdata;
        end
    end

    kwlex_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .req_type (in_type_reg),
        .in_char  (in_char_reg),
        .step     (step)
    );

    // Result queue pointers and fill count
    assign pop          = m_axis_tvalid && m_axis_tready;
    assign wr_ptr_plus1 = wr_ptr_reg + kwlex_pkg::Q_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (fire)
        begin
            wr_ptr_next = wr_ptr_reg + kwlex_pkg::Q_PTR_W'(step.count);
        end
        rd_ptr_next = pop ? rd_ptr_reg + kwlex_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg
                      + (fire ? kwlex_pkg::Q_CNT_W'(step.count) : kwlex_pkg::Q_CNT_W'(0))
                      - kwlex_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write up to two tokens per stepped beat
    always_ff @(posedge clk)
    begin
        if (fire && (step.count != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= step.first;
        end
        if (fire && (step.count == 2'd2))
        begin
            queue_reg[wr_ptr_plus1] <= step.second;
        end
    end

    // Drive the output beat from the queue head
    assign head          = queue_reg[rd_ptr_reg];
    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tdata  = {head.truncated, head.length, head.start};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyword token lexer.
// ----------------------------------------------------------------------------
// A scoreboard class models the lexer beat by beat: modes, kept length,
// token origin, stream offset, keyword candidates and overflow. Every byte
// accepted on the input stream updates the model and queues the tokens it
// should cause. Every token accepted on the output stream is checked field
// by field against the oldest queued token. A short directed text covers the
// punctuation, a keyword, comments, high bytes and end of input. Random
// token-shaped text follows, with whitespace or no gap between tokens, long
// identifiers and numbers that saturate, and stray bytes. Both streams stall
// at random, apart from one quiet stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import kwlex_pkg::*;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;
    localparam int RANDOM_BEATS  = 650;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [START_W-1:0]  start;
        logic [LENGTH_W-1:0] length;
        logic                truncated;
        logic                last;
    } token_rec_t;

    // Keyword spellings in token order
    function automatic string keyword_text(input int k);
        case (k)
            0: return "network";
            1: return "input";
            2: return "conv2d";
            3: return "maxpool2d";
            4: return "flatten";
            5: return "dense";
            6: return "output";
            default: return "train";
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Token scoreboard: lexer model plus queue of tokens still due
    // ------------------------------------------------------------------------
    class token_board_t;
        logic [1:0]             mode;
        logic [LENGTH_W-1:0]    kept;
        logic [OFFSET_BITS-1:0] origin;
        logic [OFFSET_BITS-1:0] position;
        logic [KW_COUNT-1:0]    candidates;
        logic                   overflow;
        token_rec_t             tokens_due[$];
        int                     errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode       = MODE_IDLE;
            kept       = '0;
            origin     = '0;
            position   = '0;
            candidates = '1;
            overflow   = 1'b0;
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        function bit letter(input logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit numeral(input logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit blank(input logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        // Keep only keywords whose character at pos is c
        function logic [KW_COUNT-1:0] match_keywords(input logic [KW_COUNT-1:0] cand,
                                                     input int pos, input logic [7:0] c);
            logic [KW_COUNT-1:0] hit;
            string               w;
            hit = '0;
            for (int k = 0; k < KW_COUNT; k++)
            begin
                w = keyword_text(k);
                hit[k] = cand[k] && pos < w.len() && w[pos] == c;
            end
            return hit;
        endfunction

        function void queue_token(input logic [KIND_W-1:0] kind,
                                  input logic [OFFSET_BITS-1:0] start,
                                  input logic [LENGTH_W-1:0] length, input logic trunc);
            token_rec_t t;
            t.kind      = kind;
            t.start     = start[START_W-1:0];
            t.length    = length;
            t.truncated = trunc;
            t.last      = 1'b0;
            tokens_due.push_back(t);
        endfunction

        // Emit the identifier or number in progress, if any
        function void flush_word();
            logic [KIND_W-1:0] kind;
            string             w;
            if (mode == MODE_IDENT)
            begin
                kind = KIND_IDENT;
                for (int k = 0; k < KW_COUNT; k++)
                begin
                    w = keyword_text(k);
                    if (candidates[k] && w.len() == int'(kept))
                    begin
                        kind = KIND_KW_BASE + KIND_W'(k);
                    end
                end
                queue_token(kind, origin, kept, overflow);
                mode = MODE_IDLE;
            end
            else if (mode == MODE_NUMBER)
            begin
                queue_token(KIND_NUMBER, origin, kept, overflow);
                mode = MODE_IDLE;
            end
        endfunction

        // Advance the model by one accepted input beat
        function void lex_beat(input logic req, input logic [7:0] c);
            logic [OFFSET_BITS-1:0] here;
            logic [KIND_W-1:0]      kind;
            int                     before_cnt;
            before_cnt = tokens_due.size();
            here = position;
            if (req == REQ_EOF)
            begin
                flush_word();
                queue_token(KIND_EOF, here, '0, 1'b0);
                tokens_due[tokens_due.size() - 1].last = 1'b1;
                clear_state();
                return;
            end
            position = here + 1'b1;

            if (mode == MODE_COMMENT)
            begin
                if (c == CH_LF)
                begin
                    mode = MODE_IDLE;
                end
                return;
            end
            if (mode == MODE_IDENT)
            begin
                if (letter(c) || numeral(c) || c == CH_UNDER)
                begin
                    if (kept < LENGTH_W'(IDENT_KEEP))
                    begin
                        candidates = match_keywords(candidates, int'(kept), c);
                        kept++;
                    end
                    else
                    begin
                        overflow = 1'b1;
                    end
                    return;
                end
                flush_word();
            end
            else if (mode == MODE_NUMBER)
            begin
                if (numeral(c))
                begin
                    if (kept < LENGTH_W'(NUMBER_KEEP))
                    begin
                        kept++;
                    end
                    else
                    begin
                        overflow = 1'b1;
                    end
                    return;
                end
                flush_word();
            end

            // Lex the byte afresh from idle
            if (blank(c))
            begin
                // skip whitespace
            end
            else if (c == CH_HASH)
            begin
                mode = MODE_COMMENT;
            end
            else if (letter(c) || numeral(c))
            begin
                origin   = here;
                kept     = LENGTH_W'(1);
                overflow = 1'b0;
                if (letter(c))
                begin
                    mode       = MODE_IDENT;
                    candidates = match_keywords('1, 0, c);
                end
                else
                begin
                    mode       = MODE_NUMBER;
                    candidates = '1;
                end
            end
            else
            begin
                case (c)
                    CH_LBRACE: kind = KIND_LBRACE;
                    CH_RBRACE: kind = KIND_RBRACE;
                    CH_LPAREN: kind = KIND_LPAREN;
                    CH_RPAREN: kind = KIND_RPAREN;
                    CH_COMMA:  kind = KIND_COMMA;
                    CH_EQUALS: kind = KIND_EQUALS;
                    CH_COLON:  kind = KIND_COLON;
                    default:   kind = KIND_UNKNOWN;
                endcase
                queue_token(kind, here, LENGTH_W'(1), 1'b0);
            end
            if (tokens_due.size() > before_cnt)
            begin
                tokens_due[tokens_due.size() - 1].last = 1'b1;
            end
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Check one token taken from the output stream
        function void take_token(input token_rec_t got);
            token_rec_t want;
            if (tokens_due.size() == 0)
            begin
                $display("%0t: token kind %0d start %0h arrived, expected none, actual extra",
                         $time, got.kind, got.start);
                errors++;
                return;
            end
            want = tokens_due.pop_front();
            compare_field("token_kind", 32'(want.kind), 32'(got.kind));
            compare_field("token_start", 32'(want.start), 32'(got.start));
            compare_field("token_length", 32'(want.length), 32'(got.length));
            compare_field("truncated", 32'(want.truncated), 32'(got.truncated));
            compare_field("last_of_run", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = REQ_CHAR;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tlast;

    token_board_t board = new();
    bit           steady = 1'b0;
    int           beats_sent = 0;

    keyword_token_lexer_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    // Stall the token stream at random outside the quiet stretch
    always @(negedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 36);
    end

    // Check every token beat taken at a rising edge
    always @(posedge clk)
    begin
        token_rec_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind      = m_axis_tuser;
            got.start     = m_axis_tdata[31:0];
            got.length    = m_axis_tdata[38:32];
            got.truncated = m_axis_tdata[39];
            got.last      = m_axis_tlast;
            board.take_token(got);
        end
    end

    // Drive one input beat; called and returning at a falling edge
    task automatic send_beat(input logic req, input logic [7:0] c);
        while (!steady && $urandom_range(0, 99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= req;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        board.lex_beat(req, c);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_beat(REQ_CHAR, s[i]);
        end
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] pick_word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 52)
        begin
            return pick_letter();
        end
        return (r < 62) ? 8'("0" + r - 52) : CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 6))
            0: return CH_LBRACE;
            1: return CH_RBRACE;
            2: return CH_LPAREN;
            3: return CH_RPAREN;
            4: return CH_COMMA;
            5: return CH_EQUALS;
            default: return CH_COLON;
        endcase
    endfunction

    // Keyword, sometimes cut short or followed by one more word character
    task automatic send_keyword();
        string w;
        int    n;
        w = keyword_text($urandom_range(0, KW_COUNT - 1));
        n = w.len();
        if ($urandom_range(0, 99) < 15)
        begin
            n--;
        end
        for (int i = 0; i < n; i++)
        begin
            send_beat(REQ_CHAR, w[i]);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            send_beat(REQ_CHAR, pick_word_char());
        end
    endtask

    task automatic send_ident();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(IDENT_KEEP - 2, IDENT_KEEP + 8)
                                         : $urandom_range(1, 10);
        send_beat(REQ_CHAR, pick_letter());
        for (int i = 1; i < n; i++)
        begin
            send_beat(REQ_CHAR, pick_word_char());
        end
    endtask

    task automatic send_number();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(NUMBER_KEEP - 3, NUMBER_KEEP + 7)
                                         : $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            send_beat(REQ_CHAR, 8'("0" + $urandom_range(0, 9)));
        end
    endtask

    // Comment with random body, ended by a line feed or by end of input
    task automatic send_comment();
        send_beat(REQ_CHAR, CH_HASH);
        repeat ($urandom_range(0, 8))
        begin
            send_beat(REQ_CHAR, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) == 0)
        begin
            send_beat(REQ_EOF, 8'($urandom_range(0, 255)));
        end
        else
        begin
            send_beat(REQ_CHAR, CH_LF);
        end
    endtask

    // Stimulus
    initial
    begin
        int pick;
        int goal;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: punctuation, keyword ended by a paren, comment, high bytes,
        // end of input after a number and inside a comment
        send_text("{}(),=:train(9 x_1#c\n");
        send_beat(REQ_CHAR, 8'h80);
        send_beat(REQ_CHAR, 8'hFF);
        send_text("7");
        send_beat(REQ_EOF, 8'h00);
        send_text("#z");
        send_beat(REQ_EOF, 8'hFF);

        // Random token-shaped text, with a quiet stretch in the middle
        goal = beats_sent + RANDOM_BEATS;
        while (beats_sent < goal)
        begin
            steady = (beats_sent >= goal - 400) && (beats_sent < goal - 250);
            pick = $urandom_range(0, 99);
            if (pick < 25)
                send_keyword();
            else if (pick < 40)
                send_ident();
            else if (pick < 52)
                send_number();
            else if (pick < 70)
                send_beat(REQ_CHAR, pick_punct());
            else if (pick < 78)
                send_comment();
            else if (pick < 90)
                send_beat(REQ_CHAR, 8'($urandom_range(0, 255)));
            else if (pick < 94)
                send_beat(REQ_EOF, 8'($urandom_range(0, 255)));
            else
                send_beat(REQ_CHAR, pick_space());
            if ($urandom_range(0, 1) == 1)
            begin
                send_beat(REQ_CHAR, pick_space());
            end
        end
        send_beat(REQ_EOF, 8'($urandom_range(0, 255)));
        s_axis_tvalid <= 1'b0;

        // Drain remaining tokens, then let the pipeline settle
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
